/* rtl/srb_pkg.sv */
package srb_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] KIND_RELEASE = 2'd0;
    localparam logic [1:0] KIND_HELD    = 2'd1;
    localparam logic [1:0] KIND_STALE   = 2'd2;
    localparam logic [1:0] KIND_BEYOND  = 2'd3;

    typedef struct packed {
        logic wr;
        logic clr;
        logic rd;
    } t_slot_req;

endpackage

/* rtl/srb_slots.sv */
module srb_slots #(
    parameter int DEPTH = srb_pkg::DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  srb_pkg::t_slot_req       i_req,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [31:0]              i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_clr_addr,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    input  logic [$clog2(DEPTH)-1:0] i_look_addr,
    output logic                     o_look_valid,
    output logic [31:0]              o_rd_data
);

    logic [DEPTH-1:0] r_valid;
    logic [31:0]      r_mem [DEPTH];
    logic [31:0]      r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (i_req.clr) begin
                r_valid[i_clr_addr] <= 1'b0;
            end
            if (i_req.wr) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_req.rd) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_look_valid = r_valid[i_look_addr];
    assign o_rd_data    = r_rd_data;

endmodule

/* rtl/sequence_reorder_buffer.sv */
// Reorder buffer that takes items tagged with a 32-bit sequence number in any
// order and releases them strictly in sequence order, one result transaction per
// cycle at most. An item whose number lies within DEPTH of the next expected
// number is stored in its own slot; stale, duplicate and out-of-window numbers
// come back as a single status transaction. A stored item that releases nothing
// is reported as held. The input is not ready while an item is being worked on:
// each item passes acceptance, the offset subtractor and the slot check, and a
// dropped item then loads its status result. A held result adds a further state,
// and each released item adds a registered read of the payload memory and a load
// of the output register. A single item causes at most 16 results; slots left
// over are released by the following items, after a dropped item's status
// result. Output back-pressure stalls the sequencer.
module sequence_reorder_buffer #(
    parameter int DEPTH = srb_pkg::DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // seq_index, payload
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // out_index, out_payload
    output logic [1:0]  o_m_axis_tuser,   // kind
    output logic        o_m_axis_tlast
);

    localparam int AW = $clog2(DEPTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CALC  = 3'd1;
    localparam logic [2:0] S_CLASS = 3'd2;
    localparam logic [2:0] S_DROP  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_HELD  = 3'd5;
    localparam logic [2:0] S_RD    = 3'd6;
    localparam logic [2:0] S_REL   = 3'd7;

    logic [2:0]                 r_state, n_state;
    logic [31:0]                r_seq, n_seq;
    logic [31:0]                r_pay, n_pay;
    logic [31:0]                r_diff, n_diff;
    logic [31:0]                r_next_exp, n_next_exp;
    logic [AW-1:0]              r_head, n_head;
    logic [1:0]                 r_dkind, n_dkind;
    logic [srb_pkg::CNT_W-1:0]  r_cnt, n_cnt;

    logic                       r_ovalid, n_ovalid;
    logic [1:0]                 r_okind, n_okind;
    logic [31:0]                r_oidx, n_oidx;
    logic [31:0]                r_opay, n_opay;
    logic                       r_olast, n_olast;

    srb_pkg::t_slot_req         slot_req;
    logic [AW-1:0]              look_addr;
    logic                       look_valid;
    logic [31:0]                rd_data;
    logic [AW:0]                slot_sum;
    logic [AW-1:0]              slot_addr;
    logic [AW-1:0]              head_next;
    logic                       out_free;
    logic [srb_pkg::CNT_W-1:0]  cnt_inc;
    logic                       rel_last;

    srb_slots #(
        .DEPTH(DEPTH)
    ) u_slots (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (slot_req),
        .i_wr_addr   (slot_addr),
        .i_wr_data   (r_pay),
        .i_clr_addr  (r_head),
        .i_rd_addr   (r_head),
        .i_look_addr (look_addr),
        .o_look_valid(look_valid),
        .o_rd_data   (rd_data)
    );

    assign slot_sum  = {1'b0, r_head} + {1'b0, r_diff[AW-1:0]};
    assign slot_addr = (slot_sum >= (AW+1)'(DEPTH)) ? AW'(slot_sum - (AW+1)'(DEPTH))
                                                    : slot_sum[AW-1:0];
    assign head_next = (r_head == AW'(DEPTH - 1)) ? '0 : AW'(r_head + 1'b1);
    assign out_free  = !r_ovalid || i_m_axis_tready;
    assign cnt_inc   = r_cnt + 1'b1;
    assign rel_last  = (cnt_inc == srb_pkg::CNT_W'(srb_pkg::MAX_RESULTS)) || !look_valid;

    always_comb begin
        n_state    = r_state;
        n_seq      = r_seq;
        n_pay      = r_pay;
        n_diff     = r_diff;
        n_next_exp = r_next_exp;
        n_head     = r_head;
        n_dkind    = r_dkind;
        n_cnt      = r_cnt;
        n_ovalid   = r_ovalid && !i_m_axis_tready;
        n_okind    = r_okind;
        n_oidx     = r_oidx;
        n_opay     = r_opay;
        n_olast    = r_olast;
        slot_req   = '0;
        look_addr  = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_seq   = i_s_axis_tdata[31:0];
                    n_pay   = i_s_axis_tdata[63:32];
                    n_cnt   = '0;
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                n_diff  = r_seq - r_next_exp;
                n_state = S_CLASS;
            end
            S_CLASS: begin
                look_addr = slot_addr;
                if (r_diff[31]) begin
                    n_dkind = srb_pkg::KIND_STALE;
                    n_state = S_DROP;
                end else if (r_diff[30:0] >= 31'(DEPTH)) begin
                    n_dkind = srb_pkg::KIND_BEYOND;
                    n_state = S_DROP;
                end else if (look_valid) begin
                    n_dkind = srb_pkg::KIND_STALE;
                    n_state = S_DROP;
                end else begin
                    slot_req.wr = 1'b1;
                    n_state     = S_CHECK;
                end
            end
            S_DROP: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_okind  = r_dkind;
                    n_oidx   = r_seq;
                    n_opay   = '0;
                    n_olast  = !look_valid;
                    n_cnt    = cnt_inc;
                    n_state  = look_valid ? S_RD : S_IDLE;
                end
            end
            S_CHECK: begin
                n_state = look_valid ? S_RD : S_HELD;
            end
            S_HELD: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_okind  = srb_pkg::KIND_HELD;
                    n_oidx   = r_seq;
                    n_opay   = '0;
                    n_olast  = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_RD: begin
                slot_req.rd = 1'b1;
                n_state     = S_REL;
            end
            S_REL: begin
                look_addr = head_next;
                if (out_free) begin
                    slot_req.clr = 1'b1;
                    n_ovalid     = 1'b1;
                    n_okind      = srb_pkg::KIND_RELEASE;
                    n_oidx       = r_next_exp;
                    n_opay       = rd_data;
                    n_olast      = rel_last;
                    n_next_exp   = r_next_exp + 32'd1;
                    n_head       = head_next;
                    n_cnt        = cnt_inc;
                    n_state      = rel_last ? S_IDLE : S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_next_exp <= '0;
            r_head     <= '0;
            r_cnt      <= '0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_next_exp <= n_next_exp;
            r_head     <= n_head;
            r_cnt      <= n_cnt;
            r_ovalid   <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seq   <= n_seq;
        r_pay   <= n_pay;
        r_diff  <= n_diff;
        r_dkind <= n_dkind;
        r_okind <= n_okind;
        r_oidx  <= n_oidx;
        r_opay  <= n_opay;
        r_olast <= n_olast;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {r_opay, r_oidx};
    assign o_m_axis_tuser  = r_okind;
    assign o_m_axis_tlast  = r_olast;

endmodule
